// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the tokenizer RTL.
// Defining ASSERT_OFF removes every assertion from the build.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// prop must hold at every edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// whenever trig holds, prop must hold one edge later
`define ASSERT_NEXT(lbl, clk, rstn, trig, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, trig, prop)

`endif

`endif

// ----- rtl/core/cst_pkg.sv -----
// Scan mode codes and character constants for the tokenizer.
// No dependencies.
package cst_pkg;

    localparam int MODE_W = 3;

    localparam logic [MODE_W-1:0] MODE_BETWEEN = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SLASH   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LINE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BLOCK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STAR    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_TOKEN   = 3'd5;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // output beat kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // command on the input side
    localparam logic CMD_DATA = 1'b0;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    function automatic logic is_space(input logic [7:0] b);
        is_space = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    endfunction

endpackage

// ----- rtl/core/comment_stripping_tokenizer.sv -----
// Comment-stripping whitespace tokenizer, top level.
// Depends on cst_pkg and assert_macros.svh.
//
//  channel   dir   tdata                            tuser        tlast
//  s_        in    [7:0] text_byte                  command      -
//  m_        out   [7:0] value, [8+:LINE_BITS] line kind         last of item
//  cfg_      in    cfg_wr_data = max_token_length (write only)
//
// An input beat is scanned in the cycle it is accepted; its zero to two result
// beats land in a 4-entry output queue, leaving one per cycle with m_tready high.
// With m_tready high an item giving one result or none never stalls the input;
// two-result items raise the queue level by one each and can stall the input.
// s_tready drops while fewer than two queue entries are free.
// aresetn is synchronous, active low.
// m_tready low only fills the queue; no state is lost under back-pressure.
`include "assert_macros.svh"

module comment_stripping_tokenizer #(
    parameter int LINE_BITS = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] text_byte
    input  logic                 s_tuser,   // [0] command

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [((8 + LINE_BITS + 7) / 8) * 8 - 1:0] m_tdata, // [7:0] value, then line_number
    output logic                 m_tuser,   // [0] kind
    output logic                 m_tlast
);

    localparam int TDATA_W = ((8 + LINE_BITS + 7) / 8) * 8;
    localparam logic [LINE_BITS-1:0] LINE_TOP = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

    logic [cst_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [7:0]                 kept_reg, kept_next;
    logic [LINE_BITS-1:0]       line_reg, line_next, line_base;
    logic [7:0]                 max_reg;

    logic                       kind_q   [cst_pkg::FIFO_DEPTH];
    logic [7:0]                 value_q  [cst_pkg::FIFO_DEPTH];
    logic [LINE_BITS-1:0]       line_q   [cst_pkg::FIFO_DEPTH];
    logic                       last_q   [cst_pkg::FIFO_DEPTH];
    logic [cst_pkg::PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [cst_pkg::CNT_W-1:0]  cnt_reg;

    logic       s_accept, m_pop;
    logic [7:0] b;
    logic       b_space;
    logic [1:0] n_res;
    logic       r0_kind, r1_kind;
    logic [7:0] r0_val, r1_val;

    assign s_accept = s_tvalid && s_tready;
    assign m_pop    = m_tvalid && m_tready;
    assign s_tready = (cnt_reg <= cst_pkg::CNT_W'(cst_pkg::FIFO_DEPTH - 2));
    assign b        = s_tdata;
    assign b_space  = cst_pkg::is_space(b);

    always_comb begin
        mode_next = mode_reg;
        kept_next = kept_reg;
        line_base = line_reg;
        line_next = line_reg;
        n_res     = 2'd0;
        r0_kind   = cst_pkg::KIND_BYTE;
        r0_val    = 8'd0;
        r1_kind   = cst_pkg::KIND_BYTE;
        r1_val    = 8'd0;
        if (s_accept) begin
            if (s_tuser != cst_pkg::CMD_DATA) begin
                // end of input: flush a held slash or an open token
                if (mode_reg == cst_pkg::MODE_SLASH) begin
                    if (max_reg != 8'd0) begin
                        r0_val  = cst_pkg::CH_SLASH;
                        r1_kind = cst_pkg::KIND_END;
                        n_res   = 2'd2;
                    end else begin
                        r0_kind = cst_pkg::KIND_END;
                        n_res   = 2'd1;
                    end
                end else if (mode_reg == cst_pkg::MODE_TOKEN) begin
                    r0_kind = cst_pkg::KIND_END;
                    n_res   = 2'd1;
                end
                mode_next = cst_pkg::MODE_BETWEEN;
                kept_next = 8'd0;
                line_next = LINE_ONE;
            end else begin
                unique case (mode_reg)
                    cst_pkg::MODE_BETWEEN: begin
                        if (b_space) begin
                            mode_next = cst_pkg::MODE_BETWEEN;
                        end else if (b == cst_pkg::CH_HASH) begin
                            mode_next = cst_pkg::MODE_LINE;
                        end else if (b == cst_pkg::CH_SLASH) begin
                            mode_next = cst_pkg::MODE_SLASH;
                        end else begin
                            mode_next = cst_pkg::MODE_TOKEN;
                            if (max_reg != 8'd0) begin
                                r0_val    = b;
                                n_res     = 2'd1;
                                kept_next = 8'd1;
                            end else begin
                                kept_next = 8'd0;
                            end
                        end
                    end
                    cst_pkg::MODE_SLASH: begin
                        if (b == cst_pkg::CH_SLASH) begin
                            mode_next = cst_pkg::MODE_LINE;
                        end else if (b == cst_pkg::CH_STAR) begin
                            mode_next = cst_pkg::MODE_BLOCK;
                        end else if (max_reg != 8'd0) begin
                            // held slash opens the token, then this byte
                            mode_next = cst_pkg::MODE_TOKEN;
                            r0_val    = cst_pkg::CH_SLASH;
                            n_res     = 2'd1;
                            kept_next = 8'd1;
                            if (b_space) begin
                                r1_kind   = cst_pkg::KIND_END;
                                n_res     = 2'd2;
                                kept_next = 8'd0;
                                mode_next = cst_pkg::MODE_BETWEEN;
                            end else if (max_reg > 8'd1) begin
                                r1_val    = b;
                                n_res     = 2'd2;
                                kept_next = 8'd2;
                            end
                        end else begin
                            mode_next = cst_pkg::MODE_TOKEN;
                            kept_next = 8'd0;
                            if (b_space) begin
                                r0_kind   = cst_pkg::KIND_END;
                                n_res     = 2'd1;
                                mode_next = cst_pkg::MODE_BETWEEN;
                            end
                        end
                    end
                    cst_pkg::MODE_LINE: begin
                        if (b == cst_pkg::CH_LF) begin
                            mode_next = cst_pkg::MODE_BETWEEN;
                        end
                    end
                    cst_pkg::MODE_BLOCK: begin
                        if (b == cst_pkg::CH_STAR) begin
                            mode_next = cst_pkg::MODE_STAR;
                        end
                    end
                    cst_pkg::MODE_STAR: begin
                        if (b == cst_pkg::CH_SLASH) begin
                            mode_next = cst_pkg::MODE_BETWEEN;
                        end else if (b != cst_pkg::CH_STAR) begin
                            mode_next = cst_pkg::MODE_BLOCK;
                        end
                    end
                    cst_pkg::MODE_TOKEN: begin
                        if (b_space) begin
                            r0_kind   = cst_pkg::KIND_END;
                            n_res     = 2'd1;
                            kept_next = 8'd0;
                            mode_next = cst_pkg::MODE_BETWEEN;
                        end else if (kept_reg < max_reg) begin
                            r0_val    = b;
                            n_res     = 2'd1;
                            kept_next = kept_reg + 8'd1;
                        end
                    end
                    default: begin
                        mode_next = cst_pkg::MODE_BETWEEN;
                        kept_next = 8'd0;
                        line_base = LINE_ONE;
                    end
                endcase
                line_next = line_base;
                if (b == cst_pkg::CH_LF && line_base != LINE_TOP) begin
                    line_next = line_base + LINE_ONE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= cst_pkg::MODE_BETWEEN;
            kept_reg   <= 8'd0;
            line_reg   <= LINE_ONE;
            max_reg    <= 8'd31;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            mode_reg   <= mode_next;
            kept_reg   <= kept_next;
            line_reg   <= line_next;
            if (cfg_wr_en) begin
                max_reg <= cfg_wr_data;
            end
            wr_ptr_reg <= wr_ptr_reg + cst_pkg::PTR_W'(n_res);
            if (m_pop) begin
                rd_ptr_reg <= rd_ptr_reg + cst_pkg::PTR_W'(1);
            end
            cnt_reg <= cnt_reg + cst_pkg::CNT_W'(n_res) - cst_pkg::CNT_W'(m_pop);
        end
    end

    // result queue payload, no reset needed
    always_ff @(posedge aclk) begin
        if (n_res != 2'd0) begin
            kind_q[wr_ptr_reg]  <= r0_kind;
            value_q[wr_ptr_reg] <= r0_val;
            line_q[wr_ptr_reg]  <= line_reg;
            last_q[wr_ptr_reg]  <= (n_res == 2'd1);
        end
        if (n_res == 2'd2) begin
            kind_q[wr_ptr_reg + cst_pkg::PTR_W'(1)]  <= r1_kind;
            value_q[wr_ptr_reg + cst_pkg::PTR_W'(1)] <= r1_val;
            line_q[wr_ptr_reg + cst_pkg::PTR_W'(1)]  <= line_reg;
            last_q[wr_ptr_reg + cst_pkg::PTR_W'(1)]  <= 1'b1;
        end
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = TDATA_W'({line_q[rd_ptr_reg], value_q[rd_ptr_reg]});
    assign m_tuser  = kind_q[rd_ptr_reg];
    assign m_tlast  = last_q[rd_ptr_reg];

    `ASSERT_CLK(a_cnt_bound, aclk, aresetn, cnt_reg <= cst_pkg::CNT_W'(cst_pkg::FIFO_DEPTH))
    `ASSERT_CLK(a_room_on_accept, aclk, aresetn, !s_accept || cnt_reg <= cst_pkg::CNT_W'(2))
    `ASSERT_CLK(a_mode_legal, aclk, aresetn, mode_reg <= cst_pkg::MODE_TOKEN)
    `ASSERT_NEXT(a_eoi_clears, aclk, aresetn, s_accept && s_tuser,
        mode_reg == cst_pkg::MODE_BETWEEN && kept_reg == 8'd0 && line_reg == LINE_ONE)
    `ASSERT_CLK(a_no_space_byte, aclk, aresetn,
        !(m_tvalid && m_tuser == cst_pkg::KIND_BYTE) || !cst_pkg::is_space(m_tdata[7:0]))

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for comment_stripping_tokenizer.
// Drives text beats with random idling and back-pressure, predicts every result beat
// in place and compares field by field; depends on cst_pkg and the tokenizer RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cst_pkg::*;

    localparam logic CMD_END   = 1'b1;
    localparam int   PRED      = -1;      // row expectation comes from the predictor
    localparam int   LONG_HOLD = 100;
    localparam int   WDOG_MAX  = 2000;
    localparam int   PHASE_LEN = 150;

    typedef struct packed {
        logic        kind;
        logic [7:0]  value;
        logic [23:0] line;
        logic        last;
    } tok_beat_t;

    typedef struct {
        logic       cmd;
        logic [7:0] ch;
        int         n_lit;
        tok_beat_t  r0;
        tok_beat_t  r1;
    } dir_row_t;

    localparam tok_beat_t NO_BEAT = '{KIND_BYTE, 8'h00, 24'd0, 1'b0};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;    // [7:0] text_byte
    logic        s_tuser = 1'b0;     // [0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;            // [7:0] value, [31:8] line_number
    logic        m_tuser;            // [0] kind
    logic        m_tlast;

    // predictor state
    logic [2:0]  scan_st   = MODE_BETWEEN;
    logic [7:0]  kept_n    = 8'd0;
    logic [23:0] line_no   = 24'd1;
    logic [7:0]  tok_limit = 8'd31;

    tok_beat_t   token_q[$];
    int          err_cnt = 0;
    int          items_sent = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          rx_stall = 0;
    bit          rx_hold_req = 1'b0;
    int          idle_cyc = 0;

    // directed rows; typed-in beats where they are obvious
    dir_row_t dir_tab [30] = '{
        '{CMD_DATA, "a",      1, '{KIND_BYTE, "a", 24'd1, 1'b1}, NO_BEAT},
        '{CMD_DATA, 8'hFF,    1, '{KIND_BYTE, 8'hFF, 24'd1, 1'b1}, NO_BEAT},
        '{CMD_DATA, 8'h00,    1, '{KIND_BYTE, 8'h00, 24'd1, 1'b1}, NO_BEAT},
        '{CMD_DATA, CH_SPACE, 1, '{KIND_END, 8'h00, 24'd1, 1'b1}, NO_BEAT},
        '{CMD_DATA, CH_HASH,  0, NO_BEAT, NO_BEAT},
        '{CMD_DATA, "x",      0, NO_BEAT, NO_BEAT},
        '{CMD_DATA, CH_LF,    0, NO_BEAT, NO_BEAT},
        '{CMD_DATA, CH_SLASH, 0, NO_BEAT, NO_BEAT},
        '{CMD_DATA, "q",      PRED, NO_BEAT, NO_BEAT},
        '{CMD_DATA, CH_TAB,   1, '{KIND_END, 8'h00, 24'd2, 1'b1}, NO_BEAT},
        '{CMD_DATA, CH_SLASH, 0, NO_BEAT, NO_BEAT},
        '{CMD_DATA, CH_SLASH, 0, NO_BEAT, NO_BEAT},
        '{CMD_DATA, CH_CR,    0, NO_BEAT, NO_BEAT},
        '{CMD_DATA, CH_LF,    0, NO_BEAT, NO_BEAT},
        '{CMD_DATA, CH_SLASH, 0, NO_BEAT, NO_BEAT},
        '{CMD_DATA, CH_STAR,  0, NO_BEAT, NO_BEAT},
        '{CMD_DATA, CH_STAR,  0, NO_BEAT, NO_BEAT},
        '{CMD_DATA, CH_STAR,  0, NO_BEAT, NO_BEAT},
        '{CMD_DATA, CH_SLASH, 0, NO_BEAT, NO_BEAT},
        '{CMD_DATA, "k",      1, '{KIND_BYTE, "k", 24'd3, 1'b1}, NO_BEAT},
        '{CMD_DATA, CH_HASH,  1, '{KIND_BYTE, CH_HASH, 24'd3, 1'b1}, NO_BEAT},
        '{CMD_DATA, CH_LF,    1, '{KIND_END, 8'h00, 24'd3, 1'b1}, NO_BEAT},
        '{CMD_DATA, CH_SLASH, 0, NO_BEAT, NO_BEAT},
        '{CMD_END,  8'hFF,    2, '{KIND_BYTE, CH_SLASH, 24'd4, 1'b0},
                                 '{KIND_END, 8'h00, 24'd4, 1'b1}},
        '{CMD_DATA, CH_HASH,  0, NO_BEAT, NO_BEAT},
        '{CMD_END,  8'h00,    0, NO_BEAT, NO_BEAT},
        '{CMD_DATA, CH_SLASH, 0, NO_BEAT, NO_BEAT},
        '{CMD_DATA, CH_CR,    PRED, NO_BEAT, NO_BEAT},
        '{CMD_DATA, "z",      PRED, NO_BEAT, NO_BEAT},
        '{CMD_END,  8'h5A,    1, '{KIND_END, 8'h00, 24'd1, 1'b1}, NO_BEAT}
    };

    comment_stripping_tokenizer DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic bit is_sep(logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
    endfunction

    function automatic void push_beat(logic kind, logic [7:0] val);
        tok_beat_t r;
        r.kind  = kind;
        r.value = val;
        r.line  = line_no;
        r.last  = 1'b0;
        token_q.push_back(r);
    endfunction

    // one byte inside a token: separator closes it, else kept up to the limit
    function automatic int token_step(logic [7:0] b);
        if (is_sep(b)) begin
            push_beat(KIND_END, 8'h00);
            kept_n  = 8'd0;
            scan_st = MODE_BETWEEN;
            return 1;
        end else if (kept_n < tok_limit) begin
            push_beat(KIND_BYTE, b);
            kept_n++;
            return 1;
        end
        return 0;
    endfunction

    function automatic int scan_predict(logic cmd, logic [7:0] b);
        int n;
        n = 0;
        if (cmd == CMD_END) begin
            if (scan_st == MODE_SLASH) begin
                if (tok_limit != 8'd0) begin
                    push_beat(KIND_BYTE, CH_SLASH);
                    n++;
                end
                push_beat(KIND_END, 8'h00);
                n++;
            end else if (scan_st == MODE_TOKEN) begin
                push_beat(KIND_END, 8'h00);
                n++;
            end
            scan_st = MODE_BETWEEN;
            kept_n  = 8'd0;
            line_no = 24'd1;
        end else begin
            case (scan_st)
                MODE_BETWEEN: begin
                    if (is_sep(b)) begin
                    end else if (b == CH_HASH) begin
                        scan_st = MODE_LINE;
                    end else if (b == CH_SLASH) begin
                        scan_st = MODE_SLASH;
                    end else begin
                        scan_st = MODE_TOKEN;
                        kept_n  = 8'd0;
                        n += token_step(b);
                    end
                end
                MODE_SLASH: begin
                    if (b == CH_SLASH) begin
                        scan_st = MODE_LINE;
                    end else if (b == CH_STAR) begin
                        scan_st = MODE_BLOCK;
                    end else begin
                        // held slash opens the token, then this byte
                        scan_st = MODE_TOKEN;
                        kept_n  = 8'd0;
                        n += token_step(CH_SLASH);
                        n += token_step(b);
                    end
                end
                MODE_LINE:  if (b == CH_LF) scan_st = MODE_BETWEEN;
                MODE_BLOCK: if (b == CH_STAR) scan_st = MODE_STAR;
                MODE_STAR: begin
                    if (b == CH_SLASH) scan_st = MODE_BETWEEN;
                    else if (b != CH_STAR) scan_st = MODE_BLOCK;
                end
                MODE_TOKEN: n += token_step(b);
                default: begin
                    scan_st = MODE_BETWEEN;
                    kept_n  = 8'd0;
                    line_no = 24'd1;
                end
            endcase
            if (b == CH_LF && line_no != '1) line_no++;
        end
        if (n > 0) token_q[token_q.size()-1].last = 1'b1;
        return n;
    endfunction

    // called at a rising edge; returns at the edge the beat is accepted
    task automatic send_item(input logic cmd, input logic [7:0] ch, output int n_new);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= ch;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        n_new = scan_predict(cmd, ch);
    endtask

    task automatic tx_gap();
        int k;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            k = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(0, 255));
            repeat (k) @(posedge aclk);
        end
    endtask

    task automatic feed(input logic cmd, input logic [7:0] ch);
        int n;
        send_item(cmd, ch, n);
        tx_gap();
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (token_q.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [7:0] lim);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        tok_limit = lim;
    endtask

    function automatic logic [7:0] text_char(bit first);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (is_sep(b) || (first && (b == CH_HASH || b == CH_SLASH)));
        return b;
    endfunction

    function automatic logic [7:0] sep_char();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // one random chunk of text: mostly well-formed, some partial pieces and noise
    task automatic send_text_piece();
        int         sel, len, r;
        logic [7:0] ch;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            len = ($urandom_range(0, 19) == 0) ? int'(tok_limit) + $urandom_range(1, 4)
                                                : $urandom_range(1, 10);
            feed(CMD_DATA, text_char(1));
            repeat (len - 1) feed(CMD_DATA, text_char(0));
            feed(CMD_DATA, sep_char());
        end else if (sel < 55) begin
            repeat ($urandom_range(1, 3)) feed(CMD_DATA, sep_char());
        end else if (sel < 73) begin
            if (sel < 65) begin
                feed(CMD_DATA, CH_HASH);
            end else begin
                feed(CMD_DATA, CH_SLASH);
                feed(CMD_DATA, CH_SLASH);
            end
            repeat ($urandom_range(0, 6)) begin
                do ch = 8'($urandom_range(0, 255)); while (ch == CH_LF);
                feed(CMD_DATA, ch);
            end
            feed(CMD_DATA, CH_LF);
        end else if (sel < 83) begin
            feed(CMD_DATA, CH_SLASH);
            feed(CMD_DATA, CH_STAR);
            repeat ($urandom_range(0, 8)) begin
                r = $urandom_range(0, 9);
                if (r < 3) ch = CH_STAR;
                else if (r == 3) ch = CH_LF;
                else ch = 8'($urandom_range(0, 255));
                feed(CMD_DATA, ch);
            end
            repeat ($urandom_range(1, 3)) feed(CMD_DATA, CH_STAR);
            feed(CMD_DATA, CH_SLASH);
        end else if (sel < 89) begin
            // lone slash opening a token
            feed(CMD_DATA, CH_SLASH);
            do ch = 8'($urandom_range(0, 255)); while (ch == CH_SLASH || ch == CH_STAR);
            feed(CMD_DATA, ch);
            if (!is_sep(ch)) begin
                repeat ($urandom_range(0, 3)) feed(CMD_DATA, text_char(0));
                feed(CMD_DATA, sep_char());
            end
        end else if (sel < 93) begin
            feed(CMD_END, 8'($urandom_range(0, 255)));
        end else if (sel < 97) begin
            // end of input with something still open
            case ($urandom_range(0, 3))
                0: feed(CMD_DATA, CH_SLASH);
                1: begin
                    feed(CMD_DATA, CH_HASH);
                    feed(CMD_DATA, text_char(0));
                end
                2: begin
                    feed(CMD_DATA, CH_SLASH);
                    feed(CMD_DATA, CH_STAR);
                end
                default: begin
                    feed(CMD_DATA, text_char(1));
                    feed(CMD_DATA, text_char(0));
                end
            endcase
            feed(CMD_END, 8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 4)) feed(CMD_DATA, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic check_beat();
        tok_beat_t e;
        if (token_q.size() == 0) begin
            err_cnt++;
            if (err_cnt < 50)
                $display("%0t: unexpected result beat, got kind %0d value %02h line %0d last %0d",
                         $realtime, m_tuser, m_tdata[7:0], m_tdata[31:8], m_tlast);
            return;
        end
        e = token_q.pop_front();
        if (m_tuser !== e.kind) begin
            err_cnt++;
            if (err_cnt < 50)
                $display("%0t: kind mismatch, expected %0d, got %0d", $realtime, e.kind, m_tuser);
        end
        if (m_tdata[7:0] !== e.value) begin
            err_cnt++;
            if (err_cnt < 50)
                $display("%0t: value mismatch, expected %02h, got %02h",
                         $realtime, e.value, m_tdata[7:0]);
        end
        if (m_tdata[31:8] !== e.line) begin
            err_cnt++;
            if (err_cnt < 50)
                $display("%0t: line mismatch, expected %0d, got %0d",
                         $realtime, e.line, m_tdata[31:8]);
        end
        if (m_tlast !== e.last) begin
            err_cnt++;
            if (err_cnt < 50)
                $display("%0t: last mismatch, expected %0d, got %0d", $realtime, e.last, m_tlast);
        end
    endtask

    // result side: checks beats and paces m_tready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_beat();
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_stall = LONG_HOLD;
            end else if (rx_stall == 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                rx_stall = $urandom_range(1, 7);
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cyc = 0;
        else idle_cyc++;
        if (idle_cyc >= WDOG_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        logic [7:0] phase_lim [8];
        int         n, p, start;
        phase_lim = '{8'd0, 8'd1, 8'd255, 8'd3, 8'd31, 8'd0, 8'd7, 8'd1};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows run at the reset limit
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        for (int i = 0; i < 30; i++) begin
            send_item(dir_tab[i].cmd, dir_tab[i].ch, n);
            if (dir_tab[i].n_lit != PRED) begin
                repeat (n) void'(token_q.pop_back());
                if (dir_tab[i].n_lit > 0) token_q.push_back(dir_tab[i].r0);
                if (dir_tab[i].n_lit > 1) token_q.push_back(dir_tab[i].r1);
            end
            tx_gap();
        end

        for (p = 0; p < 8; p++) begin
            wait_drained();
            set_limit((p == 6) ? 8'($urandom_range(2, 40)) : phase_lim[p]);
            tx_idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 10 : 30;
            rx_idle_pct = (p % 3 == 2) ? 0 : (p % 3 == 0) ? 15 : 35;
            if (p == 3) begin
                // long receiver hold while input keeps coming: queue fills, input stalls
                tx_idle_pct = 0;
                rx_hold_req = 1'b1;
            end
            start = items_sent;
            while (items_sent - start < PHASE_LEN) begin
                send_text_piece();
                if (p == 4 && items_sent - start > PHASE_LEN / 2 && token_q.size() > 0)
                    wait_drained();
            end
        end

        // closing stretch at full rate on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        start = items_sent;
        while (items_sent - start < PHASE_LEN) send_text_piece();

        s_tvalid <= 1'b0;
        while (token_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
